@@ sv/rsi_pkg.sv @@
// rsi_pkg: widths and payload types of the ray / sphere intersection pipeline.
// No dependencies; every other file imports it.
package rsi_pkg;

  localparam int P_W = 24;
  localparam int DIR_W = 16;
  localparam int R_W = 23;
  localparam int B_W = 30;
  localparam int C_W = 49;
  localparam int D_W = 56;
  localparam int S_W = D_W / 2;
  localparam int DISC_W = 64;
  localparam int ROOT_W = 32;

  typedef struct packed {
    logic signed [P_W-1:0]   origin_x;
    logic signed [P_W-1:0]   origin_y;
    logic signed [P_W-1:0]   origin_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [R_W-1:0]          radius;
  } rsi_ray_t;

  typedef struct packed {
    logic signed [D_W-1:0] disc;
    logic signed [B_W-1:0] b;
  } rsi_mid_t;

endpackage

@@ sv/rsi_in_if.sv @@
// rsi_in_if: ray input channel, valid / ready with the ray fields.
// Depends on rsi_pkg for field widths.
interface rsi_in_if;
  import rsi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [P_W-1:0]   origin_x;
  logic signed [P_W-1:0]   origin_y;
  logic signed [P_W-1:0]   origin_z;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic [R_W-1:0]          radius;

  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, radius,
                 input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, radius,
               output ready);
endinterface

@@ sv/rsi_out_if.sv @@
// rsi_out_if: intersection result channel, valid / ready with the result fields.
// Depends on rsi_pkg for field widths.
interface rsi_out_if;
  import rsi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DISC_W-1:0] discriminant;
  logic signed [ROOT_W-1:0] root_far;
  logic signed [ROOT_W-1:0] root_near;
  logic                     hit;

  modport source(output valid, discriminant, root_far, root_near, hit, input ready);
  modport sink(input valid, discriminant, root_far, root_near, hit, output ready);
endinterface

@@ sv/ray_sphere_intersect.sv @@
// Ray / sphere intersection by the quadratic formula, one ray per beat.
// The in_ch channel takes a ray: origin relative to the sphere center (Q12.12),
// unit direction (Q1.14) and radius (Q12.12). The out_ch channel gives one beat
// per ray: discriminant b*b - 4c (24 fraction bits), the far and near roots
// (Q20.12) and a hit flag; on a miss both roots are zero.
// The pipeline has four front-end stages (products, sums and rounding of b,
// b squared, discriminant), 14 square-root stages retiring two root bits each,
// and the output register. It takes one ray per cycle while out_ch is not stalled.
// The whole pipeline advances together; when out_ch holds a valid beat that the
// receiver does not take, every stage holds and in_ch.ready drops, so nothing
// is lost or repeated. Bubbles pass while the output register is empty.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not
// reset. Depends on rsi_pkg, rsi_in_if, rsi_out_if, rsi_front and rsi_sqrt.
module ray_sphere_intersect (
  input logic       clk,
  input logic       rst_n,
  rsi_in_if.sink    in_ch,
  rsi_out_if.source out_ch
);
  import rsi_pkg::*;

  logic     en;
  rsi_ray_t ray;
  logic     f_vld, s_vld;
  rsi_mid_t f_mid, s_mid;
  logic [S_W-1:0] s_root;

  logic signed [B_W:0]      far_sum, near_sum;
  logic                     hit_nxt;
  logic                     out_valid_r;
  logic signed [DISC_W-1:0] disc_r;
  logic signed [ROOT_W-1:0] far_r, near_r;
  logic                     hit_r;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign ray.origin_x = in_ch.origin_x;
  assign ray.origin_y = in_ch.origin_y;
  assign ray.origin_z = in_ch.origin_z;
  assign ray.dir_x = in_ch.dir_x;
  assign ray.dir_y = in_ch.dir_y;
  assign ray.dir_z = in_ch.dir_z;
  assign ray.radius = in_ch.radius;

  rsi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .ray     (ray),
    .out_vld (f_vld),
    .mid     (f_mid)
  );

  rsi_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .in_mid  (f_mid),
    .out_vld (s_vld),
    .out_mid (s_mid),
    .root    (s_root)
  );

  always_comb begin
    hit_nxt = !s_mid.disc[D_W-1];
    far_sum = -(B_W+1)'(s_mid.b) + (B_W+1)'(s_root);
    near_sum = -(B_W+1)'(s_mid.b) - (B_W+1)'(s_root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_r <= DISC_W'(s_mid.disc);
      hit_r <= hit_nxt;
      far_r <= hit_nxt ? ROOT_W'($signed(far_sum[B_W:1])) : '0;
      near_r <= hit_nxt ? ROOT_W'($signed(near_sum[B_W:1])) : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.discriminant = disc_r;
  assign out_ch.root_far = far_r;
  assign out_ch.root_near = near_r;
  assign out_ch.hit = hit_r;

`ifndef ASSERT_OFF
  a_hit_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hit_r == !disc_r[DISC_W-1]))
    else $error("hit flag disagrees with discriminant sign");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !hit_r) |-> (far_r == '0 && near_r == '0))
    else $error("nonzero root on a miss");

  a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hit_r) |-> (far_r >= near_r))
    else $error("far root below near root");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(disc_r) && $stable(far_r)))
    else $error("result changed while stalled");
`endif

endmodule

@@ sv/rsi_front.sv @@
// rsi_front: four-stage front end computing b and the discriminant b*b - 4c.
// Depends on rsi_pkg.
module rsi_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  rsi_pkg::rsi_ray_t ray,
  output logic             out_vld,
  output rsi_pkg::rsi_mid_t mid
);
  import rsi_pkg::*;

  localparam int PD_W = P_W + DIR_W;
  localparam int PP_W = 2 * P_W;
  localparam int RR_W = 2 * R_W;
  localparam int DOT_W = PD_W + 2;

  logic [3:0] vld_r;

  logic signed [PD_W-1:0] xd_r, yd_r, zd_r;
  logic signed [PP_W-1:0] xx_r, yy_r, zz_r;
  logic [RR_W-1:0]        rr_r;

  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W:0]   bt;
  logic signed [B_W-1:0]   b2_nxt, b2_r, b3_r;
  logic signed [C_W-1:0]   c_nxt, c_r;
  logic signed [2*B_W-1:0] bb;
  logic signed [D_W-1:0]   bb_r, c4_r, disc_r;
  logic signed [B_W-1:0]   b4_r;

  always_comb begin
    dot = DOT_W'(xd_r) + DOT_W'(yd_r) + DOT_W'(zd_r);
    bt = {dot, 1'b0} + (DOT_W+1)'(8192);
    b2_nxt = B_W'($signed(bt[DOT_W:14]));
    c_nxt = C_W'(xx_r) + C_W'(yy_r) + C_W'(zz_r) - {{(C_W-RR_W){1'b0}}, rr_r};
    bb = b2_r * b2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r <= ray.origin_x * ray.dir_x;
      yd_r <= ray.origin_y * ray.dir_y;
      zd_r <= ray.origin_z * ray.dir_z;
      xx_r <= ray.origin_x * ray.origin_x;
      yy_r <= ray.origin_y * ray.origin_y;
      zz_r <= ray.origin_z * ray.origin_z;
      rr_r <= ray.radius * ray.radius;
      b2_r <= b2_nxt;
      c_r <= c_nxt;
      bb_r <= bb[D_W-1:0];
      c4_r <= {{(D_W-C_W-2){c_r[C_W-1]}}, c_r, 2'b00};
      b3_r <= b2_r;
      disc_r <= bb_r - c4_r;
      b4_r <= b3_r;
    end
  end

  assign out_vld = vld_r[3];
  assign mid.disc = disc_r;
  assign mid.b = b4_r;

endmodule

@@ sv/rsi_sqrt.sv @@
// rsi_sqrt: pipelined integer square root of the discriminant, two bits per stage.
// Carries the front-end payload alongside. Depends on rsi_pkg.
module rsi_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rsi_pkg::rsi_mid_t in_mid,
  output logic              out_vld,
  output rsi_pkg::rsi_mid_t out_mid,
  output logic [rsi_pkg::S_W-1:0] root
);
  import rsi_pkg::*;

  localparam int NSTG = S_W / 2;

  function automatic logic [2*D_W-1:0] sq_step(input logic [D_W-1:0] v,
                                               input logic [D_W-1:0] res,
                                               input logic [D_W-1:0] bitv);
    logic [D_W-1:0] t;
    t = res + bitv;
    if (v >= t) begin
      return {v - t, (res >> 1) + bitv};
    end
    return {v, res >> 1};
  endfunction

  logic           vld_r [NSTG];
  logic [D_W-1:0] v_r   [NSTG];
  logic [D_W-1:0] res_r [NSTG];
  rsi_mid_t       mid_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam logic [D_W-1:0] BIT0 = D_W'(1) << (D_W - 2 - 4 * k);
    localparam logic [D_W-1:0] BIT1 = D_W'(1) << (D_W - 4 - 4 * k);
    logic           vi;
    logic [D_W-1:0] v_in, r_in, vm, rm, vo, ro;
    rsi_mid_t       mi;

    if (k == 0) begin : g_head
      assign vi = in_vld;
      assign mi = in_mid;
      assign v_in = in_mid.disc[D_W-1] ? '0 : D_W'(in_mid.disc);
      assign r_in = '0;
    end else begin : g_body
      assign vi = vld_r[k-1];
      assign mi = mid_r[k-1];
      assign v_in = v_r[k-1];
      assign r_in = res_r[k-1];
    end

    always_comb begin
      {vm, rm} = sq_step(v_in, r_in, BIT0);
      {vo, ro} = sq_step(vm, rm, BIT1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k] <= vo;
        res_r[k] <= ro;
        mid_r[k] <= mi;
      end
    end
  end

  assign out_vld = vld_r[NSTG-1];
  assign out_mid = mid_r[NSTG-1];
  assign root = res_r[NSTG-1][S_W-1:0];

endmodule

@@ bench/rsi_checker.sv @@
// rsi_checker: watches the ray and result channels of ray_sphere_intersect,
// predicts each result from the accepted ray and compares in order.
// Depends on rsi_pkg, rsi_in_if and rsi_out_if.
`timescale 1ns / 1ps
module rsi_checker (
  input  logic      clk,
  input  logic      rst_n,
  rsi_in_if.sink    in_ch,
  rsi_out_if.sink   out_ch,
  output int        fail_count,
  output int        pending,
  output int        hit_count,
  output int        miss_count
);
  import rsi_pkg::*;

  typedef struct packed {
    logic signed [DISC_W-1:0] disc;
    logic signed [ROOT_W-1:0] far_r;
    logic signed [ROOT_W-1:0] near_r;
    logic                     hit;
  } hit_result_t;

  hit_result_t expected_hits[$];

  function automatic longint floor_half(longint v, longint k);
    if (v >= 0) return v / k;
    return -((-v + k - 1) / k);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic hit_result_t predict_hit(rsi_ray_t ray);
    hit_result_t rsl;
    longint px, py, pz, dx, dy, dz, rr, dotp, bq, cq, dq, sq;
    px = ray.origin_x; py = ray.origin_y; pz = ray.origin_z;
    dx = ray.dir_x; dy = ray.dir_y; dz = ray.dir_z;
    rr = longint'({1'b0, ray.radius});
    dotp = px * dx + py * dy + pz * dz;
    bq = floor_half(2 * dotp + 8192, 16384);
    cq = px * px + py * py + pz * pz - rr * rr;
    dq = bq * bq - 4 * cq;
    rsl = '0;
    rsl.disc = dq;
    if (dq >= 0) begin
      sq = int_sqrt(longint'(dq));
      rsl.far_r = ROOT_W'(clamp32(floor_half(-bq + sq, 2)));
      rsl.near_r = ROOT_W'(clamp32(floor_half(-bq - sq, 2)));
      rsl.hit = 1'b1;
    end
    return rsl;
  endfunction

  assign pending = expected_hits.size();

  always @(posedge clk) begin
    rsi_ray_t ray;
    hit_result_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      hit_count <= 0;
      miss_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        ray = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
                in_ch.dir_x, in_ch.dir_y, in_ch.dir_z, in_ch.radius};
        expected_hits.push_back(predict_hit(ray));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.hit) hit_count <= hit_count + 1;
        else miss_count <= miss_count + 1;
        if (expected_hits.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat at %0t", $time);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_hits.pop_front();
          if (exp_r.disc !== out_ch.discriminant || exp_r.far_r !== out_ch.root_far ||
              exp_r.near_r !== out_ch.root_near || exp_r.hit !== out_ch.hit) begin
            if (fail_count < 10)
              $display("mismatch at %0t: exp disc %0d far %0d near %0d hit %0b, %s",
                       $time, exp_r.disc, exp_r.far_r, exp_r.near_r, exp_r.hit,
                       $sformatf("got %0d %0d %0d %0b", out_ch.discriminant,
                                 out_ch.root_far, out_ch.root_near, out_ch.hit));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/tb_ray_sphere_intersect.sv @@
// tb_ray_sphere_intersect: drives directed and random rays with random gaps
// and result stalls; rsi_checker predicts and compares. Depends on rsi_pkg,
// the channel interfaces, ray_sphere_intersect and rsi_checker.
`timescale 1ns / 1ps
module tb_ray_sphere_intersect;
  import rsi_pkg::*;

  localparam int N_RANDOM = 1530;
  localparam int LATENCY = 19;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, hit_count, miss_count;
  int   idle_cycles = 0;
  int   ray_count = 0;

  rsi_in_if  in_ch();
  rsi_out_if out_ch();

  ray_sphere_intersect dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  rsi_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                   .fail_count(fail_count), .pending(pending),
                   .hit_count(hit_count), .miss_count(miss_count));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = gap_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_ray(rsi_ray_t ray);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.origin_x <= ray.origin_x;
    in_ch.origin_y <= ray.origin_y;
    in_ch.origin_z <= ray.origin_z;
    in_ch.dir_x <= ray.dir_x;
    in_ch.dir_y <= ray.dir_y;
    in_ch.dir_z <= ray.dir_z;
    in_ch.radius <= ray.radius;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ray_count++;
  endtask

  function automatic logic [15:0] unit_dir();
    case ($urandom_range(0, 3))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom_range(0, 16384));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rsi_ray_t random_ray();
    rsi_ray_t ray;
    int scale;
    ray = rsi_ray_t'($bits(rsi_ray_t)'({$urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom}));
    if ($urandom_range(0, 3) != 0) begin
      scale = $urandom_range(4, 22);
      ray.origin_x = 24'($signed($urandom) >>> (32 - scale));
      ray.origin_y = 24'($signed($urandom) >>> (32 - scale));
      ray.origin_z = 24'($signed($urandom) >>> (32 - scale));
      ray.radius = 23'($urandom >> (32 - scale - $urandom_range(0, 1)));
      ray.dir_x = unit_dir();
      ray.dir_y = unit_dir() >>> $urandom_range(0, 4);
      ray.dir_z = unit_dir() >>> $urandom_range(0, 4);
    end
    return ray;
  endfunction

  initial begin
    rsi_ray_t ray;
    int wait_cnt;
    in_ch.valid = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
    {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z, in_ch.radius} = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_ray('{24'sd0, 24'sd0, 24'sd0, 16'sd16384, 16'sd0, 16'sd0, 23'd4096});
    send_ray('{-24'sd40960, 24'sd0, 24'sd0, 16'sd16384, 16'sd0, 16'sd0, 23'd4096});
    send_ray('{-24'sd40960, 24'sd20000, 24'sd0, 16'sd16384, 16'sd0, 16'sd0, 23'd4096});
    send_ray('{-24'sd40960, 24'sd4096, 24'sd0, 16'sd16384, 16'sd0, 16'sd0, 23'd4096});
    send_ray('{24'sd8388607, 24'sd8388607, 24'sd8388607,
               16'sd32767, 16'sd32767, 16'sd32767, 23'd8388607});
    send_ray('{-24'sd8388608, -24'sd8388608, -24'sd8388608,
               -16'sd32768, -16'sd32768, -16'sd32768, 23'd0});
    send_ray('{-24'sd8388608, -24'sd8388608, -24'sd8388608,
               16'sd32767, 16'sd32767, 16'sd32767, 23'd8388607});
    send_ray('{24'sd8388607, -24'sd8388608, 24'sd0, -16'sd32768, 16'sd32767, 16'sd0, 23'd1});
    send_ray('{24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 23'd0});
    send_ray('{24'sd0, 24'sd0, 24'sd1, 16'sd0, 16'sd0, 16'sd0, 23'd0});
    send_ray('{24'sd100, 24'sd0, 24'sd0, 16'sd8000, 16'sd3000, 16'sd0, 23'd8388607});
    send_ray('{24'sd1, 24'sd1, 24'sd0, 16'sd1, 16'sd0, 16'sd0, 23'd1});
    send_ray('{24'sd0, 24'sd0, -24'sd81920, 16'sd0, 16'sd0, -16'sd16384, 23'd8192});

    wait_cnt = 0;
    in_ch.valid <= 1'b0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end

    repeat (N_RANDOM) begin
      ray = random_ray();
      send_ray(ray);
    end
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d rays: %0d hits and %0d misses returned, directed extremes included.",
             ray_count, hit_count, miss_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
